@@ rtl/core/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the pack handle LRU cache: table size,
// field widths, result status codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package plc_pkg;

	// Table geometry
	localparam int SLOTS = 8;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Field widths
	localparam int DETAIL_W = 2;
	localparam int BLOCK_W  = 32;
	localparam int STAMP_W  = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 3;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_HIT     = 3'd0,
		ST_FILL    = 3'd1,
		ST_REPLACE = 3'd2,
		ST_NOFILE  = 3'd3,
		ST_FLUSH   = 3'd4
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;         // capture the incoming item
		logic commit_cmp;   // finish a hit, fill, no-file or flush
		logic scan_start;   // seed the oldest-entry scan with slot 0
		logic scan_step;    // compare one more stamp
		logic commit_repl;  // replace the oldest entry
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic need_scan;    // miss on a full table with the file available
		logic scan_last;    // scan is at the last slot
		logic out_busy;     // result register holds an item not yet taken
	} dp_sts_t;

endpackage

@@ rtl/core/pack_handle_lru_cache.sv @@
// ----------------------------------------------------------------------------
// pack_handle_lru_cache
// Fully associative handle cache keyed by (detail, block index) with
// least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each item is a lookup (cmd 0) or a flush (cmd 1) and yields exactly one
// result. Hits, fills of an empty slot, file-missing misses and flushes go
// through acceptance of the item and the parallel key compare over all
// slots. A miss on a full table then runs the age scan, which reads one
// stored stamp per cycle to find the least recently used entry, before the
// replacement is committed. The result sits in an output register, so the
// next item is accepted while an earlier result still waits to be taken;
// the block only holds when a new result is ready and that register is full.
// ----------------------------------------------------------------------------
module pack_handle_lru_cache (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [plc_pkg::DETAIL_W-1:0] detail,
	input  logic [plc_pkg::BLOCK_W-1:0]  block_index,
	input  logic                         file_ok,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [plc_pkg::STATUS_W-1:0] status,
	output logic [plc_pkg::SLOT_W-1:0]   slot,
	output logic [plc_pkg::DETAIL_W-1:0] evicted_detail,
	output logic [plc_pkg::BLOCK_W-1:0]  evicted_block
);

	plc_pkg::ctl_cmd_t ctl_cmd;
	plc_pkg::dp_sts_t  dp_sts;

	plc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	plc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl_cmd),
		.sts            (dp_sts),
		.cmd_in         (cmd),
		.detail         (detail),
		.block_index    (block_index),
		.file_ok        (file_ok),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.slot           (slot),
		.evicted_detail (evicted_detail),
		.evicted_block  (evicted_block)
	);

endmodule

@@ rtl/core/plc_ctrl.sv @@
// ----------------------------------------------------------------------------
// plc_ctrl
// Sequencer for the cache: accepts one item, runs the key compare, walks
// the stamps on a replacement and hands the result to the output register.
// ----------------------------------------------------------------------------
module plc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  plc_pkg::dp_sts_t  sts,
	output plc_pkg::ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_SCAN = 4'b0100,
		S_REPL = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.need_scan) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else if (!sts.out_busy) begin
					cmd.commit_cmp = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_REPL;
				end
			end
			S_REPL: begin
				if (!sts.out_busy) begin
					cmd.commit_repl = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/plc_dp.sv @@
// ----------------------------------------------------------------------------
// plc_dp
// Datapath for the cache: item registers, key and stamp table, access
// counter, parallel key compare, one-stamp-per-cycle age scan and the
// result register.
// ----------------------------------------------------------------------------
module plc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  plc_pkg::ctl_cmd_t                  cmd,
	output plc_pkg::dp_sts_t                   sts,
	input  logic                               cmd_in,
	input  logic [plc_pkg::DETAIL_W-1:0]       detail,
	input  logic [plc_pkg::BLOCK_W-1:0]        block_index,
	input  logic                               file_ok,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [plc_pkg::STATUS_W-1:0]       status,
	output logic [plc_pkg::SLOT_W-1:0]         slot,
	output logic [plc_pkg::DETAIL_W-1:0]       evicted_detail,
	output logic [plc_pkg::BLOCK_W-1:0]        evicted_block
);

	// Captured item
	logic                         flush_q;
	logic [plc_pkg::DETAIL_W-1:0] detail_q;
	logic [plc_pkg::BLOCK_W-1:0]  block_q;
	logic                         file_ok_q;

	// Table and bookkeeping
	logic [plc_pkg::DETAIL_W-1:0] ent_detail_q [plc_pkg::SLOTS];
	logic [plc_pkg::BLOCK_W-1:0]  ent_block_q  [plc_pkg::SLOTS];
	logic [plc_pkg::STAMP_W-1:0]  ent_stamp_q  [plc_pkg::SLOTS];
	logic [plc_pkg::CNT_W-1:0]    filled_q;
	logic [plc_pkg::STAMP_W-1:0]  counter_q;

	// Scan state
	logic [plc_pkg::IDX_W-1:0]    scan_idx_q;
	logic [plc_pkg::IDX_W-1:0]    best_idx_q;
	logic [plc_pkg::STAMP_W-1:0]  best_age_q;
	logic [plc_pkg::STAMP_W-1:0]  scan_age;

	// Result register
	logic                         out_valid_q;
	logic [plc_pkg::STATUS_W-1:0] status_q;
	logic [plc_pkg::SLOT_W-1:0]   slot_q;
	logic [plc_pkg::DETAIL_W-1:0] ev_detail_q;
	logic [plc_pkg::BLOCK_W-1:0]  ev_block_q;

	// Compare and write control
	logic [plc_pkg::SLOTS-1:0]    hit_vec;
	logic                         hit_any;
	logic [plc_pkg::IDX_W-1:0]    hit_idx;
	logic                         full;
	logic                         do_hit;
	logic                         do_fill;
	logic                         wr_key;
	logic                         wr_en;
	logic [plc_pkg::IDX_W-1:0]    wr_idx;

	// Compare the item key against every slot in use
	always_comb begin
		for (int i = 0; i < plc_pkg::SLOTS; i++) begin
			hit_vec[i] = (plc_pkg::CNT_W'(i) < filled_q) &&
				(ent_detail_q[i] == detail_q) && (ent_block_q[i] == block_q);
		end
	end

	// Pick the lowest matching slot
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = plc_pkg::SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_any = 1'b1;
				hit_idx = plc_pkg::IDX_W'(i);
			end
		end
	end

	assign full     = (filled_q == plc_pkg::CNT_W'(plc_pkg::SLOTS));
	assign scan_age = counter_q - ent_stamp_q[scan_idx_q];

	// Status toward the controller
	assign sts.need_scan = !flush_q && !hit_any && file_ok_q && full;
	assign sts.scan_last = (scan_idx_q == plc_pkg::IDX_W'(plc_pkg::SLOTS - 1));
	assign sts.out_busy  = out_valid_q && out_stall;

	// Select the table write
	always_comb begin
		do_hit  = cmd.commit_cmp && !flush_q && hit_any;
		do_fill = cmd.commit_cmp && !flush_q && !hit_any && file_ok_q && !full;
		wr_en   = do_hit || do_fill || cmd.commit_repl;
		wr_key  = do_fill || cmd.commit_repl;
		if (do_hit) begin
			wr_idx = hit_idx;
		end else if (do_fill) begin
			wr_idx = plc_pkg::IDX_W'(filled_q);
		end else begin
			wr_idx = best_idx_q;
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			flush_q   <= cmd_in;
			detail_q  <= detail;
			block_q   <= block_index;
			file_ok_q <= file_ok;
		end
	end

	// Write keys and stamps
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_stamp_q[wr_idx] <= counter_q;
			if (wr_key) begin
				ent_detail_q[wr_idx] <= detail_q;
				ent_block_q[wr_idx]  <= block_q;
			end
		end
	end

	// Advance the access counter and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			filled_q  <= '0;
		end else begin
			if (cmd.load && !cmd_in) begin
				counter_q <= counter_q + 1'b1;
			end
			if (cmd.commit_cmp && flush_q) begin
				filled_q <= '0;
			end else if (do_fill) begin
				filled_q <= filled_q + 1'b1;
			end
		end
	end

	// Walk the stamps, keep the oldest; ties stay with the lower slot
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_idx_q <= plc_pkg::IDX_W'(1);
			best_idx_q <= '0;
			best_age_q <= counter_q - ent_stamp_q[0];
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (scan_age > best_age_q) begin
				best_idx_q <= scan_idx_q;
				best_age_q <= scan_age;
			end
		end
	end

	// Result valid: set on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit_cmp || cmd.commit_repl) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.commit_repl) begin
			status_q    <= plc_pkg::ST_REPLACE;
			slot_q      <= plc_pkg::SLOT_W'(best_idx_q);
			ev_detail_q <= ent_detail_q[best_idx_q];
			ev_block_q  <= ent_block_q[best_idx_q];
		end else if (cmd.commit_cmp) begin
			ev_detail_q <= '0;
			ev_block_q  <= '0;
			if (flush_q) begin
				status_q <= plc_pkg::ST_FLUSH;
				slot_q   <= '0;
			end else if (hit_any) begin
				status_q <= plc_pkg::ST_HIT;
				slot_q   <= plc_pkg::SLOT_W'(hit_idx);
			end else if (!file_ok_q) begin
				status_q <= plc_pkg::ST_NOFILE;
				slot_q   <= '0;
			end else begin
				status_q <= plc_pkg::ST_FILL;
				slot_q   <= plc_pkg::SLOT_W'(filled_q);
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign slot           = slot_q;
	assign evicted_detail = ev_detail_q;
	assign evicted_block  = ev_block_q;

endmodule

@@ rtl/core/plc_checker.sv @@
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks for the pack handle LRU cache, bound to the top level.
// ----------------------------------------------------------------------------
module plc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [plc_pkg::STATUS_W-1:0] status,
	input logic [plc_pkg::SLOT_W-1:0]   slot,
	input logic [plc_pkg::DETAIL_W-1:0] evicted_detail,
	input logic [plc_pkg::BLOCK_W-1:0]  evicted_block
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot) &&
			$stable(evicted_detail) && $stable(evicted_block))
		else $error("stalled result changed");

	// One item at a time: after an accepted item the input stalls
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting an item");

	// Only a replacement reports an evicted key
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != plc_pkg::ST_REPLACE) |->
			(evicted_detail == '0) && (evicted_block == '0))
		else $error("evicted key shown without a replacement");

	// Flush and file-missing results carry slot zero; status stays in range
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == plc_pkg::ST_HIT) || (status == plc_pkg::ST_FILL) ||
			(status == plc_pkg::ST_REPLACE) ||
			(((status == plc_pkg::ST_NOFILE) || (status == plc_pkg::ST_FLUSH)) &&
				(slot == '0))))
		else $error("bad status or nonzero slot");

endmodule

bind pack_handle_lru_cache plc_checker u_plc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.slot           (slot),
	.evicted_detail (evicted_detail),
	.evicted_block  (evicted_block)
);
